FILE: rtl/smf_pkg.sv
// ----------------------------------------------------------------------------
// smf_pkg: shared types and constants of the separable median filter
// Item types for both streams, configuration indexes and default sizes.
// ----------------------------------------------------------------------------
package smf_pkg;

  localparam int unsigned WINDOW_DEF   = 7;
  localparam int unsigned MAX_LINE_DEF = 2048;

  localparam logic [11:0] PAD_WIDTH_RST  = 12'd2048;
  localparam logic [15:0] PAD_HEIGHT_RST = 16'd65535;

  typedef enum logic [0:0] {
    CFG_PAD_WIDTH  = 1'b0,
    CFG_PAD_HEIGHT = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] pixel;
    logic       frame_start;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] median;
    logic       frame_end;
  } med_out_t;

endpackage

FILE: rtl/smf_cell.sv
// ----------------------------------------------------------------------------
// smf_cell: one tap of the horizontal pixel window
// Holds one pixel and takes its neighbour's pixel whenever the row shifts.
// ----------------------------------------------------------------------------
module smf_cell (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       shift_i,
  input  logic [7:0] pix_i,
  output logic [7:0] pix_o
);

  logic [7:0] pix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_q <= '0;
    end else if (shift_i) begin
      pix_q <= pix_i;
    end
  end

  assign pix_o = pix_q;

endmodule

FILE: rtl/smf_median.sv
// ----------------------------------------------------------------------------
// smf_median: median of N bytes by parallel rank counting
// Each value counts the values ranked below it; ties go by position.
// ----------------------------------------------------------------------------
module smf_median #(
  parameter int unsigned N = smf_pkg::WINDOW_DEF
) (
  input  logic [7:0] val_i [N],
  output logic [7:0] med_o
);

  localparam int unsigned RW = $clog2(N);

  always_comb begin
    logic [RW-1:0] rank;
    med_o = '0;
    for (int i = 0; i < N; i++) begin
      rank = '0;
      for (int j = 0; j < N; j++) begin
        if (j != i && ((val_i[j] < val_i[i]) || (val_i[j] == val_i[i] && j < i))) begin
          rank = rank + RW'(1);
        end
      end
      if (rank == RW'(N / 2)) begin
        med_o = val_i[i];
      end
    end
  end

endmodule

FILE: rtl/smf_line_store.sv
// ----------------------------------------------------------------------------
// smf_line_store: ring of row-median lines
// One byte-wide bank per line; all banks read at one column, one bank written.
// ----------------------------------------------------------------------------
module smf_line_store #(
  parameter int unsigned LINES = smf_pkg::WINDOW_DEF - 1,
  parameter int unsigned DEPTH = smf_pkg::MAX_LINE_DEF
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [$clog2(LINES)-1:0] slot_i,
  input  logic [7:0]               wdata_i,
  output logic [7:0]               rdata_o [LINES]
);

  for (genvar b = 0; b < LINES; b++) begin : g_bank
    logic [7:0] mem [DEPTH];
    logic [7:0] rd_q;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rd_q <= mem[addr_i];
        if (slot_i == ($clog2(LINES))'(b)) begin
          mem[addr_i] <= wdata_i;
        end
      end
    end

    assign rdata_o[b] = rd_q;
  end

endmodule

FILE: rtl/separable_median_filter.sv
// ----------------------------------------------------------------------------
// separable_median_filter: two-stage median filter over a padded grey image
// Row median over a sliding window, then median of the row medians of the
// last WINDOW rows at the same column, held in a ring of line stores.
// ----------------------------------------------------------------------------
//
//   Channel  | Handshake                  | Payload
//   ---------+----------------------------+--------------------------------
//   input    | in_valid_i / in_ready_o    | in_data_i  (pixel, frame_start)
//   output   | out_valid_o / out_ready_i  | out_data_o (median, frame_end)
//   config   | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//
// One item is taken every clock cycle while no result is held back; a result
// passes from the window stage, loaded at the accepting edge, through the
// registered line-store read to the output register.
// Each stage moves on when the next one is empty or moving, so a waiting
// result stalls only what is behind it and bubbles are squeezed out.
// Reset clears the window, the counts and the pipeline; the line stores are
// not cleared, since every entry is written before it is read in a frame.
// Configuration writes are always taken.
module separable_median_filter #(
  parameter int unsigned WINDOW   = smf_pkg::WINDOW_DEF,
  parameter int unsigned MAX_LINE = smf_pkg::MAX_LINE_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  smf_pkg::pix_in_t   in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output smf_pkg::med_out_t  out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  smf_pkg::cfg_idx_e  cfg_index_i,
  input  logic [15:0]        cfg_data_i
);

  localparam int unsigned LINES = WINDOW - 1;
  localparam int unsigned CW    = $clog2(MAX_LINE);
  localparam int unsigned SW    = $clog2(LINES);

  // Configuration registers.
  logic [11:0] pw_q;
  logic [15:0] ph_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pw_q <= smf_pkg::PAD_WIDTH_RST;
      ph_q <= smf_pkg::PAD_HEIGHT_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        smf_pkg::CFG_PAD_WIDTH:  pw_q <= cfg_data_i[11:0];
        smf_pkg::CFG_PAD_HEIGHT: ph_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The row width is clipped to the line-store depth.
  logic [CW:0] width_eff;
  always_comb begin
    if (32'(pw_q) > 32'(MAX_LINE)) begin
      width_eff = (CW+1)'(MAX_LINE);
    end else begin
      width_eff = (CW+1)'(pw_q);
    end
  end

  // Pipeline handshake: every stage moves when the one ahead can take it.
  logic v1_q, v2_q, ov_q;
  logic rdy2, rdy3, adv1, in_acc;

  assign rdy3       = !ov_q || out_ready_i;
  assign rdy2       = !v2_q || rdy3;
  assign adv1       = v1_q && rdy2;
  assign in_ready_o = !v1_q || rdy2;
  assign in_acc     = in_valid_i && in_ready_o;

  // Column, row and line-slot counts.
  logic [CW-1:0] col_q, col_d, c_cur;
  logic [15:0]   row_q, row_d, r_cur;
  logic [SW-1:0] slot_q, slot_d, s_cur;

  always_comb begin
    c_cur = in_data_i.frame_start ? '0 : col_q;
    r_cur = in_data_i.frame_start ? '0 : row_q;
    s_cur = in_data_i.frame_start ? '0 : slot_q;
    col_d  = c_cur + CW'(1);
    row_d  = r_cur;
    slot_d = s_cur;
    if (({1'b0, c_cur} + (CW+1)'(1)) >= width_eff) begin
      col_d = '0;
      if ((17'(r_cur) + 17'd1) >= 17'(ph_q)) begin
        row_d  = '0;
        slot_d = '0;
      end else begin
        row_d  = r_cur + 16'd1;
        slot_d = (s_cur == SW'(LINES - 1)) ? '0 : s_cur + SW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      slot_q <= '0;
    end else if (in_acc) begin
      col_q  <= col_d;
      row_q  <= row_d;
      slot_q <= slot_d;
    end
  end

  // Horizontal window: a chain of cells that shifts on every accepted item.
  logic [7:0] win [WINDOW];
  for (genvar k = 0; k < WINDOW; k++) begin : g_cell
    logic [7:0] feed;
    if (k == WINDOW - 1) begin : g_last
      assign feed = in_data_i.pixel;
    end else begin : g_mid
      assign feed = win[k+1];
    end
    smf_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (in_acc),
      .pix_i   (feed),
      .pix_o   (win[k])
    );
  end

  // Stage 1: item whose window is full; the window stays put while it waits,
  // since no new pixel is taken until this stage moves.
  logic          full, emit, fend;
  logic [CW-1:0] x1_q;
  logic [SW-1:0] s1_q;
  logic          em1_q, fe1_q;

  assign full = c_cur >= CW'(WINDOW - 1);
  assign emit = r_cur >= 16'(WINDOW - 1);
  assign fend = (ph_q != 16'd0) && (r_cur == ph_q - 16'd1)
                && ({1'b0, c_cur} == width_eff - (CW+1)'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (in_ready_o) begin
      v1_q <= in_acc && full;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      x1_q  <= c_cur - CW'(WINDOW - 1);
      s1_q  <= s_cur;
      em1_q <= emit;
      fe1_q <= fend;
    end
  end

  logic [7:0] row_med;
  smf_median #(.N(WINDOW)) u_row_med (
    .val_i (win),
    .med_o (row_med)
  );

  // Stage 2: line-store read at the column, row median written to its slot.
  logic [7:0] rd [LINES];
  smf_line_store #(.LINES(LINES), .DEPTH(MAX_LINE)) u_lines (
    .clk_i   (clk_i),
    .en_i    (adv1),
    .addr_i  (x1_q),
    .slot_i  (s1_q),
    .wdata_i (row_med),
    .rdata_o (rd)
  );

  logic [7:0] rm2_q;
  logic       em2_q, fe2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (rdy2) begin
      v2_q <= adv1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      rm2_q <= row_med;
      em2_q <= em1_q;
      fe2_q <= fe1_q;
    end
  end

  // Stage 3: vertical median, only from the seventh row of the frame on.
  logic [7:0] col_vals [WINDOW];
  logic [7:0] col_med;
  always_comb begin
    for (int i = 0; i < LINES; i++) begin
      col_vals[i] = rd[i];
    end
    col_vals[WINDOW-1] = rm2_q;
  end

  smf_median #(.N(WINDOW)) u_col_med (
    .val_i (col_vals),
    .med_o (col_med)
  );

  smf_pkg::med_out_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (rdy3) begin
      ov_q <= v2_q && em2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy3 && v2_q && em2_q) begin
      out_q.median    <= col_med;
      out_q.frame_end <= fe2_q;
    end
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = out_q;

endmodule

FILE: tb/tb_separable_median_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_separable_median_filter: self-checking bench of the 7x7 median filter
// Streams padded frames of several sizes through the block with random
// back-pressure on both sides. A behavioural copy of the filter predicts
// every filtered pixel, and each output item is compared in arrival order.
// ----------------------------------------------------------------------------
module tb_separable_median_filter;

  // Window size and line length as the block is built.
  localparam int unsigned Win     = smf_pkg::WINDOW_DEF;
  localparam int unsigned LineLen = smf_pkg::MAX_LINE_DEF;
  // Cycles without any handshake before the run is declared hung.
  localparam int unsigned HangLimit = 5000;
  // Length of the single long receiver hold-off.
  localparam int unsigned LongHold  = 300;

  typedef enum int {PAT_ZERO, PAT_MAX, PAT_RAMP, PAT_SALT, PAT_RAND} pattern_e;

  // One directed phase: register values, frame count, pixel pattern and,
  // where it is obvious, the value every filtered pixel must take.
  typedef struct {
    logic [15:0] width_w;
    logic [15:0] height_w;
    int          frames;
    pattern_e    pat;
    bit          fixed;
    logic [7:0]  fixed_val;
  } phase_t;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_ready_o;
  smf_pkg::pix_in_t  in_data_i = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  smf_pkg::med_out_t out_data_o;
  logic     cfg_valid_i = 1'b0;
  logic     cfg_ready_o;
  smf_pkg::cfg_idx_e cfg_index_i = smf_pkg::CFG_PAD_WIDTH;
  logic [15:0] cfg_data_i = '0;

  separable_median_filter u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Shadow copy of the filter: pixel window, ring of row-median lines,
  // raster counters and the two size registers.
  logic [7:0]  win_px [Win];
  logic [7:0]  median_rows [Win-1][LineLen];
  int unsigned col_pos, row_pos;
  int unsigned pad_w, pad_h;

  smf_pkg::med_out_t filtered_q[$];
  int unsigned mismatches, pixels_sent, pixels_random, medians_seen, phases_run;
  int unsigned ramp_val;
  bit          calm;       // no idling on either side in the closing phase
  bit          hold_req;   // asks the receiver for one long hold-off
  int unsigned quiet_cycles;

  // Middle value of seven: the element with three or fewer smaller
  // values below it and enough equal ones to cover rank three.
  function automatic logic [7:0] mid_of_seven(input logic [7:0] v [Win]);
    int lt, eq;
    for (int i = 0; i < Win; i++) begin
      lt = 0;
      eq = 0;
      for (int j = 0; j < Win; j++) begin
        if (v[j] < v[i]) lt++;
        else if (v[j] == v[i]) eq++;
      end
      if (lt <= Win / 2 && lt + eq > Win / 2) return v[i];
    end
    return v[0];
  endfunction

  // Advances the shadow filter by one pixel; returns 1 with the filtered
  // item when this pixel completes a 7x7 window.
  function automatic bit filter_pixel(input smf_pkg::pix_in_t px,
                                      output smf_pkg::med_out_t res);
    int unsigned w, x, slot;
    logic [7:0] tmp [Win];
    logic [7:0] rmed;
    bit got;
    got = 1'b0;
    res = '0;
    w = (pad_w > LineLen) ? LineLen : pad_w;
    if (px.frame_start) begin
      col_pos = 0;
      row_pos = 0;
    end
    for (int i = 0; i < Win - 1; i++) win_px[i] = win_px[i+1];
    win_px[Win-1] = px.pixel;
    if (col_pos >= Win - 1 && col_pos < LineLen + Win - 1) begin
      x    = col_pos - (Win - 1);
      slot = row_pos % (Win - 1);
      rmed = mid_of_seven(win_px);
      if (row_pos >= Win - 1) begin
        for (int i = 0; i < Win - 1; i++) tmp[i] = median_rows[i][x];
        tmp[Win-1]    = rmed;
        res.median    = mid_of_seven(tmp);
        res.frame_end = (pad_h != 0 && row_pos == pad_h - 1 && col_pos == w - 1);
        got = 1'b1;
      end
      median_rows[slot][x] = rmed;
    end
    // Both counters wrap at the end of the frame, so a following frame
    // needs no frame_start.
    if (col_pos + 1 >= w) begin
      col_pos = 0;
      row_pos = (row_pos + 1 >= pad_h) ? 0 : row_pos + 1;
    end else begin
      col_pos++;
    end
    return got;
  endfunction

  function automatic logic [7:0] pick_pixel(input pattern_e pat);
    int unsigned r;
    case (pat)
      PAT_ZERO: return 8'd0;
      PAT_MAX:  return 8'd255;
      PAT_RAMP: begin
        ramp_val = ramp_val + 3;
        return ramp_val[7:0];
      end
      PAT_SALT: begin
        // Salt-and-pepper: mostly mid grey with scattered black and white.
        r = $urandom_range(0, 9);
        if (r < 2) return 8'd0;
        if (r < 4) return 8'd255;
        return 8'(100 + $urandom_range(0, 60));
      end
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Writes one register; only called while the block is idle.
  task automatic write_reg(input smf_pkg::cfg_idx_e idx, input logic [15:0] val);
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    if (idx == smf_pkg::CFG_PAD_WIDTH) pad_w = val[11:0];
    else pad_h = val;
  endtask

  // Offers one pixel, maybe after a random gap, and predicts its result
  // once the block has taken it. With a fixed value the typed expectation
  // replaces the predicted median.
  task automatic send_pixel(input smf_pkg::pix_in_t px, input bit fixed,
                            input logic [7:0] fval);
    smf_pkg::med_out_t res;
    int unsigned gap;
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 8);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= px;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pixels_sent++;
    if (filter_pixel(px, res)) begin
      if (fixed) res.median = fval;
      filtered_q.push_back(res);
    end
  endtask

  // Waits for every expected result plus the pipeline depth, so that a
  // register write never lands on a pixel still in flight.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (filtered_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Runs one phase: set both sizes, then stream the frames. Degenerate
  // sizes, or ones too large to fill a frame quickly, get a short burst.
  task automatic run_phase(input phase_t ph, input bit cut);
    int unsigned w, n;
    smf_pkg::pix_in_t px;
    drain();
    write_reg(smf_pkg::CFG_PAD_WIDTH, ph.width_w);
    write_reg(smf_pkg::CFG_PAD_HEIGHT, ph.height_w);
    w = (pad_w > LineLen) ? LineLen : pad_w;
    n = (w * pad_h == 0 || w * pad_h > 4000) ? 20 : w * pad_h * ph.frames;
    // A broken sequence stops part way through a frame.
    if (cut && n > 2) n = $urandom_range(1, n - 1);
    phases_run++;
    for (int unsigned k = 0; k < n; k++) begin
      px.pixel       = pick_pixel(ph.pat);
      px.frame_start = (k == 0);
      send_pixel(px, ph.fixed, ph.fixed_val);
    end
  endtask

  // Receiver: checks each output item against the oldest prediction and
  // stalls in random bursts, once for a long stretch on request.
  int unsigned stall_left;
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      medians_seen++;
      if (filtered_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected output item: median %0d frame_end %0b",
                   out_data_o.median, out_data_o.frame_end);
      end else begin
        if (out_data_o !== filtered_q[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected median %0d frame_end %0b, got %0d %0b",
                     filtered_q[0].median, filtered_q[0].frame_end,
                     out_data_o.median, out_data_o.frame_end);
        end
        void'(filtered_q.pop_front());
      end
    end
    if (stall_left != 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else if (hold_req) begin
      hold_req   <= 1'b0;
      stall_left <= LongHold;
      out_ready_i <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 7);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Watchdog: any handshake on any channel counts as progress.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni)
      quiet_cycles <= 0;
    else if (quiet_cycles >= HangLimit) begin
      $display("TEST FAILED");
      $finish;
    end else
      quiet_cycles <= quiet_cycles + 1;
  end

  phase_t directed [9];
  phase_t ph;

  initial begin
    // Register defaults and the extremes of both sizes; uniform frames
    // can only give their own value back, so theirs is typed in.
    directed[0] = '{16'h0800, 16'hFFFF, 1, PAT_RAND, 1'b0, 8'd0};  // reset values
    directed[1] = '{16'h0007, 16'h0007, 1, PAT_MAX,  1'b1, 8'd255}; // smallest frame
    directed[2] = '{16'hF007, 16'h0007, 1, PAT_ZERO, 1'b1, 8'd0};   // upper bits ignored
    directed[3] = '{16'h0007, 16'h0007, 2, PAT_RAMP, 1'b0, 8'd0};   // wrap into next frame
    directed[4] = '{16'h0006, 16'h0009, 1, PAT_RAND, 1'b0, 8'd0};   // narrower than window
    directed[5] = '{16'h0000, 16'h0008, 1, PAT_RAND, 1'b0, 8'd0};   // width of zero
    directed[6] = '{16'h000A, 16'h0000, 1, PAT_RAND, 1'b0, 8'd0};   // height of zero
    directed[7] = '{16'h0FFF, 16'h0007, 1, PAT_SALT, 1'b0, 8'd0};   // capped at line length
    directed[8] = '{16'h000A, 16'h0008, 1, PAT_SALT, 1'b0, 8'd0};

    for (int i = 0; i < Win; i++) win_px[i] = '0;
    for (int i = 0; i < Win - 1; i++)
      for (int j = 0; j < LineLen; j++) median_rows[i][j] = '0;
    col_pos = 0;
    row_pos = 0;
    pad_w = smf_pkg::PAD_WIDTH_RST;
    pad_h = smf_pkg::PAD_HEIGHT_RST;
    ramp_val = 0;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) begin
      if (i == 8) hold_req = 1'b1;  // fill the pipeline behind a long stall
      run_phase(directed[i], 1'b0);
    end

    // Random frames: mostly complete and well formed, some cut short,
    // some narrower than the window.
    while (pixels_random < 40) begin
      ph.width_w  = {4'($urandom_range(0, 15)),
                     12'(($urandom_range(0, 7) == 0) ? $urandom_range(3, 6)
                                                      : $urandom_range(7, 12))};
      ph.height_w = 16'($urandom_range(7, 8));
      ph.frames   = $urandom_range(1, 2);
      ph.pat      = pattern_e'($urandom_range(0, 4));
      ph.fixed    = 1'b0;
      ph.fixed_val = '0;
      ramp_val    = ramp_val + pixels_sent;
      begin
        int unsigned before_cnt;
        before_cnt = pixels_sent;
        run_phase(ph, $urandom_range(0, 5) == 0);
        pixels_random += pixels_sent - before_cnt;
      end
    end

    // Closing frame with steady flow on both sides.
    drain();
    calm = 1'b1;
    ph = '{16'h0009, 16'h0007, 1, PAT_RAND, 1'b0, 8'd0};
    run_phase(ph, 1'b0);
    drain();

    if (filtered_q.size() != 0) mismatches++;
    $display("Streamed %0d pixels over %0d size settings, %0d filtered pixels checked.",
             pixels_sent, phases_run, medians_seen);
    $display("Mismatches: %0d", mismatches);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/smf_pkg.sv
rtl/smf_cell.sv
rtl/smf_median.sv
rtl/smf_line_store.sv
rtl/separable_median_filter.sv
tb/tb_separable_median_filter.sv
